// ----- rtl/core/bhs_pkg.sv -----
// ----------------------------------------------------------------------------
// bhs_pkg: shared types and constants of the bilinear hysteretic spring
// Item layouts, configuration bundle and datapath word types.
// ----------------------------------------------------------------------------
package bhs_pkg;

    // APB address width: seven 32-bit registers at byte addresses 4*i
    localparam int PADDR_W = 5;

    // Reset value of the elastic stiffness register, also the history reset
    localparam logic [31:0] K0_RESET = 32'd65536;

    // Shared multiplier operand and wide accumulator words
    typedef logic signed [32:0] op_t;
    typedef logic signed [65:0] wide_t;

    typedef struct packed {
        logic signed [31:0] disp_i_x;
        logic signed [31:0] disp_i_z;
        logic signed [31:0] disp_j_x;
        logic signed [31:0] disp_j_z;
        logic               commit;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] deformation;
        logic signed [47:0] spring_force;
        logic        [31:0] tangent_stiffness;
        logic               yielded;
        logic signed [47:0] node_force_0;
        logic signed [47:0] node_force_1;
        logic signed [47:0] node_force_2;
        logic signed [47:0] node_force_3;
    } out_item_t;

    // Configuration bundle from the register file to the core
    typedef struct packed {
        logic [3:0][15:0] cos;
        logic [31:0]      k0;
        logic [30:0]      uy;
        logic [15:0]      alpha;
        logic             stiff_wr;
        logic [31:0]      stiff_wdata;
    } cfg_t;

endpackage

// ----- rtl/core/bhs_in_if.sv -----
// ----------------------------------------------------------------------------
// bhs_in_if: input channel of the bilinear hysteretic spring
// Valid/ready handshake with four node displacements and a commit flag.
// ----------------------------------------------------------------------------
interface bhs_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] disp_i_x;
    logic signed [31:0] disp_i_z;
    logic signed [31:0] disp_j_x;
    logic signed [31:0] disp_j_z;
    logic               commit;

    modport source (
        output valid, disp_i_x, disp_i_z, disp_j_x, disp_j_z, commit,
        input  ready
    );
    modport sink (
        input  valid, disp_i_x, disp_i_z, disp_j_x, disp_j_z, commit,
        output ready
    );
endinterface

// ----- rtl/core/bhs_out_if.sv -----
// ----------------------------------------------------------------------------
// bhs_out_if: result channel of the bilinear hysteretic spring
// Valid/ready handshake with deformation, forces, stiffness and branch flag.
// ----------------------------------------------------------------------------
interface bhs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] deformation;
    logic signed [47:0] spring_force;
    logic        [31:0] tangent_stiffness;
    logic               yielded;
    logic signed [47:0] node_force_0;
    logic signed [47:0] node_force_1;
    logic signed [47:0] node_force_2;
    logic signed [47:0] node_force_3;

    modport source (
        output valid, deformation, spring_force, tangent_stiffness, yielded,
               node_force_0, node_force_1, node_force_2, node_force_3,
        input  ready
    );
    modport sink (
        input  valid, deformation, spring_force, tangent_stiffness, yielded,
               node_force_0, node_force_1, node_force_2, node_force_3,
        output ready
    );
endinterface

// ----- rtl/core/bhs_cfg.sv -----
// ----------------------------------------------------------------------------
// bhs_cfg: APB configuration registers
// Direction cosines, elastic stiffness, yield deformation, hardening ratio.
// ----------------------------------------------------------------------------
module bhs_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bhs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    output logic [31:0]                 prdata,
    output bhs_pkg::cfg_t               cfg
);
    import bhs_pkg::*;

    localparam logic [2:0] REG_COS0  = 3'd0;
    localparam logic [2:0] REG_COS1  = 3'd1;
    localparam logic [2:0] REG_COS2  = 3'd2;
    localparam logic [2:0] REG_COS3  = 3'd3;
    localparam logic [2:0] REG_K0    = 3'd4;
    localparam logic [2:0] REG_UY    = 3'd5;
    localparam logic [2:0] REG_ALPHA = 3'd6;

    logic [3:0][15:0] cos_reg;
    logic [31:0]      k0_reg;
    logic [30:0]      uy_reg;
    logic [15:0]      alpha_reg;
    logic             wr_en;
    logic [2:0]       idx;

    assign wr_en = psel && penable && pwrite && pready;
    assign idx   = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg[0] <= 16'hC000;
            cos_reg[1] <= 16'h0000;
            cos_reg[2] <= 16'h4000;
            cos_reg[3] <= 16'h0000;
            k0_reg     <= K0_RESET;
            uy_reg     <= 31'd65536;
            alpha_reg  <= 16'd0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_COS0:  cos_reg[0] <= pwdata[15:0];
                REG_COS1:  cos_reg[1] <= pwdata[15:0];
                REG_COS2:  cos_reg[2] <= pwdata[15:0];
                REG_COS3:  cos_reg[3] <= pwdata[15:0];
                REG_K0:    k0_reg     <= pwdata;
                REG_UY:    uy_reg     <= pwdata[30:0];
                REG_ALPHA: alpha_reg  <= pwdata[15:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_COS0:  prdata = {16'd0, cos_reg[0]};
            REG_COS1:  prdata = {16'd0, cos_reg[1]};
            REG_COS2:  prdata = {16'd0, cos_reg[2]};
            REG_COS3:  prdata = {16'd0, cos_reg[3]};
            REG_K0:    prdata = k0_reg;
            REG_UY:    prdata = {1'b0, uy_reg};
            REG_ALPHA: prdata = {16'd0, alpha_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // A stiffness write also reloads the stored tangent stiffness in the core
    assign cfg.cos         = cos_reg;
    assign cfg.k0          = k0_reg;
    assign cfg.uy          = uy_reg;
    assign cfg.alpha       = alpha_reg;
    assign cfg.stiff_wr    = wr_en && (idx == REG_K0);
    assign cfg.stiff_wdata = pwdata;

endmodule

// ----- rtl/core/bhs_mul.sv -----
// ----------------------------------------------------------------------------
// bhs_mul: shared signed multiplier
// One 33x33 signed product per cycle, registered.
// ----------------------------------------------------------------------------
module bhs_mul (
    input  logic           clk,
    input  bhs_pkg::op_t   op_a,
    input  bhs_pkg::op_t   op_b,
    output bhs_pkg::wide_t prod
);
    import bhs_pkg::*;

    wide_t prod_reg;
    wide_t prod_next;

    assign prod_next = wide_t'(op_a) * wide_t'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/core/bhs_core.sv -----
// ----------------------------------------------------------------------------
// bhs_core: sequencer, datapath and history of the hysteretic spring
// Steps the shared multiplier through projection, bounds and node forces.
// ----------------------------------------------------------------------------
module bhs_core (
    input  logic                clk,
    input  logic                rst_n,
    input  bhs_pkg::cfg_t       cfg,
    input  logic                start,
    input  bhs_pkg::in_item_t   in_item,
    input  logic                out_free,
    output logic                busy,
    output logic                res_load,
    output bhs_pkg::out_item_t  res
);
    import bhs_pkg::*;

    // Steps: a step issues at most one product and may consume the one issued before it
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_M0   = 5'd1;
    localparam logic [4:0] S_M1   = 5'd2;
    localparam logic [4:0] S_M2   = 5'd3;
    localparam logic [4:0] S_M3   = 5'd4;
    localparam logic [4:0] S_KR   = 5'd5;
    localparam logic [4:0] S_FY   = 5'd6;
    localparam logic [4:0] S_DU   = 5'd7;
    localparam logic [4:0] S_FT   = 5'd8;
    localparam logic [4:0] S_BU   = 5'd9;
    localparam logic [4:0] S_BD   = 5'd10;
    localparam logic [4:0] S_UN   = 5'd11;
    localparam logic [4:0] S_FU   = 5'd12;
    localparam logic [4:0] S_DEC  = 5'd13;
    localparam logic [4:0] S_N0H  = 5'd14;
    localparam logic [4:0] S_N0L  = 5'd15;
    localparam logic [4:0] S_N1H  = 5'd16;
    localparam logic [4:0] S_N1L  = 5'd17;
    localparam logic [4:0] S_N2H  = 5'd18;
    localparam logic [4:0] S_N2L  = 5'd19;
    localparam logic [4:0] S_N3H  = 5'd20;
    localparam logic [4:0] S_N3L  = 5'd21;
    localparam logic [4:0] S_N3F  = 5'd22;
    localparam logic [4:0] S_OUT  = 5'd23;

    function automatic logic signed [31:0] sat32(input wide_t v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -66'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input wide_t v);
        logic signed [47:0] r;
        if (v > 66'sd140737488355327)
            r = 48'sh7FFF_FFFF_FFFF;
        else if (v < -66'sd140737488355328)
            r = 48'sh8000_0000_0000;
        else
            r = v[47:0];
        return r;
    endfunction

    logic [4:0]         state_reg;
    logic [4:0]         state_next;
    in_item_t           din_reg;
    wide_t              acc_reg;
    wide_t              prod;
    op_t                op_a;
    op_t                op_b;
    op_t                c_op [4];
    logic signed [31:0] ue_reg;
    logic        [31:0] k1_reg;
    logic signed [47:0] fy_reg;
    logic signed [31:0] du_reg;
    logic signed [31:0] tup_reg;
    logic signed [31:0] tdn_reg;
    logic signed [47:0] ftry_reg;
    logic signed [47:0] bup_reg;
    logic signed [47:0] bdn_reg;
    logic signed [47:0] funl_reg;
    logic signed [47:0] f_reg;
    logic        [31:0] k_reg;
    logic               yld_reg;
    logic signed [47:0] nf0_reg;
    logic signed [47:0] nf1_reg;
    logic signed [47:0] nf2_reg;
    logic signed [47:0] nf3_reg;
    // History
    logic signed [31:0] ld_reg;
    logic signed [31:0] li_reg;
    logic signed [47:0] lf_reg;
    logic        [31:0] ls_reg;
    logic               ly_reg;
    wide_t              p_sh16;
    wide_t              node_sum;
    op_t                f_hi_op;
    op_t                f_lo_op;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            c_op[i] = {{17{cfg.cos[i][15]}}, cfg.cos[i]};
        end
    end

    assign f_hi_op  = {{9{f_reg[47]}}, f_reg[47:24]};
    assign f_lo_op  = {9'd0, f_reg[23:0]};
    assign p_sh16   = prod >>> 16;
    assign node_sum = acc_reg + prod;

    // Operand select for the product issued in this step
    always_comb
    begin
        unique case (state_reg)
            S_M0:    begin op_a = c_op[0]; op_b = {din_reg.disp_i_x[31], din_reg.disp_i_x}; end
            S_M1:    begin op_a = c_op[1]; op_b = {din_reg.disp_i_z[31], din_reg.disp_i_z}; end
            S_M2:    begin op_a = c_op[2]; op_b = {din_reg.disp_j_x[31], din_reg.disp_j_x}; end
            S_M3:    begin op_a = c_op[3]; op_b = {din_reg.disp_j_z[31], din_reg.disp_j_z}; end
            S_KR:    begin op_a = {17'd0, cfg.alpha}; op_b = {1'b0, cfg.k0}; end
            S_FY:    begin op_a = {1'b0, cfg.k0}; op_b = {2'd0, cfg.uy}; end
            S_FT:    begin op_a = {du_reg[31], du_reg}; op_b = {1'b0, ls_reg}; end
            S_BU:    begin op_a = {1'b0, k1_reg}; op_b = {tup_reg[31], tup_reg}; end
            S_BD:    begin op_a = {1'b0, k1_reg}; op_b = {tdn_reg[31], tdn_reg}; end
            S_UN:    begin op_a = {du_reg[31], du_reg}; op_b = {1'b0, cfg.k0}; end
            S_N0H:   begin op_a = c_op[0]; op_b = f_hi_op; end
            S_N0L:   begin op_a = c_op[0]; op_b = f_lo_op; end
            S_N1H:   begin op_a = c_op[1]; op_b = f_hi_op; end
            S_N1L:   begin op_a = c_op[1]; op_b = f_lo_op; end
            S_N2H:   begin op_a = c_op[2]; op_b = f_hi_op; end
            S_N2L:   begin op_a = c_op[2]; op_b = f_lo_op; end
            S_N3H:   begin op_a = c_op[3]; op_b = f_hi_op; end
            S_N3L:   begin op_a = c_op[3]; op_b = f_lo_op; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    bhs_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign busy     = (state_reg != S_IDLE);
    assign res_load = (state_reg == S_OUT) && out_free;

    always_comb
    begin
        if (state_reg == S_IDLE)
            state_next = start ? S_M0 : S_IDLE;
        else if (state_reg == S_OUT)
            state_next = out_free ? S_IDLE : S_OUT;
        else
            state_next = state_reg + 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath: consume the product issued in the previous step
    always_ff @(posedge clk)
    begin
        if (start && (state_reg == S_IDLE))
            din_reg <= in_item;
        unique case (state_reg)
            S_M1:  acc_reg <= prod;
            S_M2:  acc_reg <= acc_reg + prod;
            S_M3:  acc_reg <= acc_reg + prod;
            S_KR:  acc_reg <= acc_reg + prod;
            S_FY:
            begin
                ue_reg <= sat32(acc_reg >>> 14);
                k1_reg <= prod[47:16];
            end
            S_DU:
            begin
                fy_reg  <= sat48(p_sh16);
                du_reg  <= sat32(wide_t'(ue_reg) - wide_t'(ld_reg));
                tup_reg <= sat32(wide_t'(ue_reg) - wide_t'({1'b0, cfg.uy}));
                tdn_reg <= sat32(wide_t'(ue_reg) + wide_t'({1'b0, cfg.uy}));
            end
            S_BU:  ftry_reg <= sat48(wide_t'(lf_reg) + p_sh16);
            S_BD:  bup_reg  <= sat48(wide_t'(fy_reg) + p_sh16);
            S_UN:  bdn_reg  <= sat48(p_sh16 - wide_t'(fy_reg));
            S_FU:  funl_reg <= sat48(wide_t'(lf_reg) + p_sh16);
            S_DEC:
            begin
                if (du_reg == 32'sd0)
                begin
                    // Zero increment: repeat the stored history
                    f_reg   <= lf_reg;
                    k_reg   <= ls_reg;
                    yld_reg <= ly_reg;
                end
                else if (!ly_reg)
                begin
                    if (du_reg > 32'sd0 && ftry_reg > bup_reg)
                    begin
                        f_reg <= bup_reg; k_reg <= k1_reg; yld_reg <= 1'b1;
                    end
                    else if (du_reg < 32'sd0 && ftry_reg < bdn_reg)
                    begin
                        f_reg <= bdn_reg; k_reg <= k1_reg; yld_reg <= 1'b1;
                    end
                    else
                    begin
                        f_reg <= ftry_reg; k_reg <= cfg.k0; yld_reg <= 1'b0;
                    end
                end
                else if ((li_reg > 32'sd0 && du_reg > 32'sd0) ||
                         (li_reg < 32'sd0 && du_reg < 32'sd0))
                begin
                    // Continued loading on the hardening branch
                    f_reg <= ftry_reg; k_reg <= k1_reg; yld_reg <= 1'b1;
                end
                else if (funl_reg > bup_reg)
                begin
                    f_reg <= bup_reg; k_reg <= k1_reg; yld_reg <= 1'b1;
                end
                else if (funl_reg < bdn_reg)
                begin
                    f_reg <= bdn_reg; k_reg <= k1_reg; yld_reg <= 1'b1;
                end
                else
                begin
                    // Elastic unloading
                    f_reg <= funl_reg; k_reg <= cfg.k0; yld_reg <= 1'b0;
                end
            end
            S_N0L: acc_reg <= prod <<< 24;
            S_N1H: nf0_reg <= sat48(node_sum >>> 14);
            S_N1L: acc_reg <= prod <<< 24;
            S_N2H: nf1_reg <= sat48(node_sum >>> 14);
            S_N2L: acc_reg <= prod <<< 24;
            S_N3H: nf2_reg <= sat48(node_sum >>> 14);
            S_N3L: acc_reg <= prod <<< 24;
            S_N3F: nf3_reg <= sat48(node_sum >>> 14);
            default: ;
        endcase
    end

    // History: commit on delivery, stiffness write reloads the stored tangent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_reg <= 32'sd0;
            li_reg <= 32'sd0;
            lf_reg <= 48'sd0;
            ls_reg <= K0_RESET;
            ly_reg <= 1'b0;
        end
        else if (cfg.stiff_wr)
        begin
            ls_reg <= cfg.stiff_wdata;
        end
        else if (res_load && din_reg.commit)
        begin
            ld_reg <= ue_reg;
            li_reg <= du_reg;
            lf_reg <= f_reg;
            ls_reg <= k_reg;
            ly_reg <= yld_reg;
        end
    end

    assign res.deformation       = ue_reg;
    assign res.spring_force      = f_reg;
    assign res.tangent_stiffness = k_reg;
    assign res.yielded           = yld_reg;
    assign res.node_force_0      = nf0_reg;
    assign res.node_force_1      = nf1_reg;
    assign res.node_force_2      = nf2_reg;
    assign res.node_force_3      = nf3_reg;

endmodule

// ----- rtl/core/bilinear_hysteretic_spring.sv -----
// ----------------------------------------------------------------------------
// bilinear_hysteretic_spring: fixed-point bilinear kinematic hardening spring
// Projects node displacements on the spring axis, runs the bilinear
// hysteresis and returns force, tangent stiffness, branch and node forces.
// ----------------------------------------------------------------------------
//
//   channel   role     handshake        contents
//   --------  -------  ---------------  ----------------------------------------
//   in_ch     sink     valid/ready      disp_i_x/z, disp_j_x/z (Q16.16), commit
//   out_ch    source   valid/ready      deformation, spring_force, stiffness,
//                                       yielded, node_force_0..3
//   APB       slave    psel/penable     cos_0..3, elastic_stiffness,
//                                       yield_disp, hardening_ratio at 4*i
//
// A transaction is accepted in the idle state and then runs 23 sequencer
// steps, set by the single shared 33x33 multiplier that forms eighteen
// products in turn (projection, k1, fy, trial force, two bounds, unloading
// force and eight half products for the node forces).
// The result register frees the core: a new input transaction is accepted as
// soon as the core is idle, even while the previous result waits on out_ch.
// A stalled out_ch holds the core in its last step; rst_n clears the
// sequencer, the configuration and the stored history asynchronously.
// ----------------------------------------------------------------------------
module bilinear_hysteretic_spring (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bhs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    bhs_in_if.sink                      in_ch,
    bhs_out_if.source                   out_ch
);
    import bhs_pkg::*;

    cfg_t      cfg;
    in_item_t  in_item;
    out_item_t res;
    out_item_t out_reg;
    logic      out_valid_reg;
    logic      out_free;
    logic      busy;
    logic      res_load;
    logic      start;

    // Every APB access completes without wait states
    assign pready = 1'b1;

    bhs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Input side: take a transaction whenever the sequencer is idle
    assign in_ch.ready      = !busy;
    assign start            = in_ch.valid && !busy;
    assign in_item.disp_i_x = in_ch.disp_i_x;
    assign in_item.disp_i_z = in_ch.disp_i_z;
    assign in_item.disp_j_x = in_ch.disp_j_x;
    assign in_item.disp_j_z = in_ch.disp_j_z;
    assign in_item.commit   = in_ch.commit;

    bhs_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .start    (start),
        .in_item  (in_item),
        .out_free (out_free),
        .busy     (busy),
        .res_load (res_load),
        .res      (res)
    );

    // Output register: free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // Hold the payload until a new result is loaded
    always_ff @(posedge clk)
    begin
        if (res_load)
            out_reg <= res;
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.deformation       = out_reg.deformation;
    assign out_ch.spring_force      = out_reg.spring_force;
    assign out_ch.tangent_stiffness = out_reg.tangent_stiffness;
    assign out_ch.yielded           = out_reg.yielded;
    assign out_ch.node_force_0      = out_reg.node_force_0;
    assign out_ch.node_force_1      = out_reg.node_force_1;
    assign out_ch.node_force_2      = out_reg.node_force_2;
    assign out_ch.node_force_3      = out_reg.node_force_3;

endmodule

// ----- test/bilinear_hysteretic_spring_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_hysteretic_spring_tb: self-checking bench of the hysteretic spring
// Drives displacement steps through the input channel and APB settings
// through the register port. Every accepted step is run through a bit-exact
// model of the projection, bilinear hysteresis and node force stage. Every
// response on the result channel is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module bilinear_hysteretic_spring_tb;

    // Register map, index i sits at byte address 4*i
    localparam int unsigned REG_COS_I_X = 0;
    localparam int unsigned REG_COS_I_Z = 1;
    localparam int unsigned REG_COS_J_X = 2;
    localparam int unsigned REG_COS_J_Z = 3;
    localparam int unsigned REG_K0      = 4;
    localparam int unsigned REG_UY      = 5;
    localparam int unsigned REG_ALPHA   = 6;
    localparam int unsigned REG_SPARE   = 7;   // first index past the map

    localparam int unsigned HOLDOFF_CYCLES = 400;
    localparam int unsigned END_SETTLE     = 48;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned MAX_REPORTS    = 10;

    localparam logic signed [31:0] ONE  = 32'sd65536;  // 1.0 in Q16.16
    localparam logic signed [31:0] HALF = 32'sd32768;
    localparam logic signed [31:0] DMAX = 32'sh7fffffff;
    localparam logic signed [31:0] DMIN = 32'sh80000000;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [bhs_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    bhs_in_if  step_ch ();
    bhs_out_if resp_ch ();

    bilinear_hysteretic_spring u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (step_ch),
        .out_ch  (resp_ch)
    );

    // Mirror of the register file
    logic signed [15:0] cfg_cos [4];
    logic        [31:0] cfg_k0;
    logic        [30:0] cfg_uy;
    logic        [15:0] cfg_alpha;

    // Mirror of the committed history
    logic signed [31:0] hist_def;
    logic signed [31:0] hist_inc;
    logic signed [47:0] hist_force;
    logic        [31:0] hist_stiff;
    logic               hist_yld;

    // Predicted responses, oldest first
    bhs_pkg::out_item_t response_forecast [$];

    // Shared knobs of the stimulus processes
    bit idle_en;
    bit holdoff_req;

    int unsigned steps_sent;
    int unsigned steps_uncommitted;
    int unsigned responses_seen;
    int unsigned yielded_seen;
    int unsigned settings_loaded;
    int unsigned mismatches;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Fixed-point model
    // ------------------------------------------------------------------------

    // Clamp to the signed range of a w-bit word
    function automatic longint sat_to(longint v, int unsigned w);
        longint lim;
        lim = longint'(1) <<< (w - 1);
        if (v > lim - 1)
            return lim - 1;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Work out the response to one step and advance the history on commit.
    // All products fit in 64 bits, and >>> on signed longint is a floor shift.
    function automatic bhs_pkg::out_item_t spring_response(bhs_pkg::in_item_t stp);
        longint c [4];
        longint d [4];
        longint acc, ue, du, k0, k1, uy, fy, f_try, f_bup, f_bdn, frc, kt, t;
        logic yl;
        bhs_pkg::out_item_t r;

        d[0] = longint'(stp.disp_i_x);
        d[1] = longint'(stp.disp_i_z);
        d[2] = longint'(stp.disp_j_x);
        d[3] = longint'(stp.disp_j_z);
        acc = 0;
        for (int i = 0; i < 4; i++)
        begin
            c[i] = longint'(cfg_cos[i]);
            acc += c[i] * d[i];
        end
        ue = sat_to(acc >>> 14, 32);

        k0 = longint'(cfg_k0);
        uy = longint'(cfg_uy);
        k1 = (longint'(cfg_alpha) * k0) >>> 16;
        fy = sat_to((k0 * uy) >>> 16, 48);

        du    = sat_to(ue - longint'(hist_def), 32);
        f_try = sat_to(longint'(hist_force) + ((du * longint'(hist_stiff)) >>> 16), 48);
        t     = sat_to(ue - uy, 32);
        f_bup = sat_to(fy + ((k1 * t) >>> 16), 48);
        t     = sat_to(ue + uy, 32);
        f_bdn = sat_to(-fy + ((k1 * t) >>> 16), 48);

        yl = hist_yld;
        if (du == 0)
        begin
            // no motion: repeat the stored force and stiffness
            kt  = longint'(hist_stiff);
            frc = longint'(hist_force);
        end
        else if (!hist_yld)
        begin
            if ((du > 0 && f_try > f_bup) || (du < 0 && f_try < f_bdn))
            begin
                frc = (du > 0) ? f_bup : f_bdn;
                kt  = k1;
                yl  = 1'b1;
            end
            else
            begin
                frc = f_try;
                kt  = k0;
            end
        end
        else if ((hist_inc > 0 && du > 0) || (hist_inc < 0 && du < 0))
        begin
            // keep moving along the hardening branch
            frc = f_try;
            kt  = k1;
        end
        else
        begin
            // reversal or no previous motion: unload on k0, then clamp
            frc = sat_to(longint'(hist_force) + ((du * k0) >>> 16), 48);
            kt  = k0;
            yl  = 1'b0;
            if (frc > f_bup)
            begin
                frc = f_bup;
                kt  = k1;
                yl  = 1'b1;
            end
            else if (frc < f_bdn)
            begin
                frc = f_bdn;
                kt  = k1;
                yl  = 1'b1;
            end
        end

        r.deformation       = ue[31:0];
        r.spring_force      = frc[47:0];
        r.tangent_stiffness = kt[31:0];
        r.yielded           = yl;
        r.node_force_0      = 48'(sat_to((c[0] * frc) >>> 14, 48));
        r.node_force_1      = 48'(sat_to((c[1] * frc) >>> 14, 48));
        r.node_force_2      = 48'(sat_to((c[2] * frc) >>> 14, 48));
        r.node_force_3      = 48'(sat_to((c[3] * frc) >>> 14, 48));

        if (stp.commit)
        begin
            hist_def   = ue[31:0];
            hist_inc   = du[31:0];
            hist_force = frc[47:0];
            hist_stiff = kt[31:0];
            hist_yld   = yl;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one step and hold it until the transaction completes, then
    // queue its predicted response. Valid stays high into the next step
    // unless a gap is drawn.
    task automatic send_step(bhs_pkg::in_item_t stp);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            step_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        step_ch.valid    <= 1'b1;
        step_ch.disp_i_x <= stp.disp_i_x;
        step_ch.disp_i_z <= stp.disp_i_z;
        step_ch.disp_j_x <= stp.disp_j_x;
        step_ch.disp_j_z <= stp.disp_j_z;
        step_ch.commit   <= stp.commit;
        do
            @(posedge clk);
        while (!step_ch.ready);
        response_forecast.push_back(spring_response(stp));
        steps_sent++;
        if (!stp.commit)
            steps_uncommitted++;
    endtask

    task automatic send_disp(logic signed [31:0] ix, logic signed [31:0] iz,
                             logic signed [31:0] jx, logic signed [31:0] jz,
                             logic cm);
        bhs_pkg::in_item_t stp;
        stp.disp_i_x = ix;
        stp.disp_i_z = iz;
        stp.disp_j_x = jx;
        stp.disp_j_z = jz;
        stp.commit   = cm;
        send_step(stp);
    endtask

    // Drop valid and wait until every predicted response has been seen,
    // then let the pipeline settle
    task automatic drain_responses();
        step_ch.valid <= 1'b0;
        while (response_forecast.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle, register taken at the access edge
    task automatic write_reg(int unsigned idx, logic [31:0] data);
        logic [31:0] byte_addr;
        byte_addr = idx << 2;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= byte_addr[bhs_pkg::PADDR_W-1:0];
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_COS_I_X, REG_COS_I_Z, REG_COS_J_X, REG_COS_J_Z:
                cfg_cos[idx[1:0]] = data[15:0];
            REG_K0:
            begin
                // a stiffness write also restarts the stored tangent
                cfg_k0     = data;
                hist_stiff = data;
            end
            REG_UY:
                cfg_uy = data[30:0];
            REG_ALPHA:
                cfg_alpha = data[15:0];
            default:
                ;   // outside the map: the block drops it
        endcase
    endtask

    // Load a full setting; unused upper bits of each word carry noise.
    // cs[0] is the end I x cosine, cs[3] the end J z one.
    task automatic load_settings(logic [3:0][15:0] cs, logic [31:0] k0,
                                 logic [30:0] uy, logic [15:0] alpha);
        logic [31:0] w;
        for (int i = 0; i < 4; i++)
        begin
            w = $urandom;
            w[15:0] = cs[i];
            write_reg(REG_COS_I_X + i, w);
        end
        write_reg(REG_K0, k0);
        w = $urandom;
        w[30:0] = uy;
        write_reg(REG_UY, w);
        w = $urandom;
        w[15:0] = alpha;
        write_reg(REG_ALPHA, w);
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_SPARE, $urandom);
        settings_loaded++;
    endtask

    // Load/unload walk along the end J x displacement with random content.
    // Mostly well-formed motion with reversals; some steps repeat the
    // previous one (zero increment) and some are full-range noise.
    task automatic run_walk(int unsigned count);
        bhs_pkg::in_item_t stp;
        bhs_pkg::in_item_t last_stp;
        longint pos, span, lim;
        int dir;
        int unsigned pick;
        pos      = 0;
        dir      = 1;
        last_stp = '0;
        lim      = longint'(1) <<< 30;
        span     = longint'(cfg_uy) >>> 1;
        if (span < 64)
            span = 64;
        if (span > (longint'(1) <<< 28))
            span = longint'(1) <<< 28;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                stp.disp_i_x = $urandom;
                stp.disp_i_z = $urandom;
                stp.disp_j_x = $urandom;
                stp.disp_j_z = $urandom;
                stp.commit   = ($urandom_range(0, 1) != 0);
            end
            else if (pick < 20)
            begin
                stp        = last_stp;
                stp.commit = ($urandom_range(0, 3) != 0);
            end
            else
            begin
                if ($urandom_range(0, 4) == 0)
                    dir = -dir;
                pos = pos + dir * longint'($urandom_range(0, int'(span)));
                if (pos > lim)
                    pos = lim;
                if (pos < -lim)
                    pos = -lim;
                stp.disp_j_x = pos[31:0];
                stp.disp_i_x = $urandom_range(0, 2047) - 1024;
                stp.disp_i_z = $urandom_range(0, 2047) - 1024;
                stp.disp_j_z = $urandom_range(0, 2047) - 1024;
                stp.commit   = ($urandom_range(0, 9) != 0);
            end
            send_step(stp);
            last_stp = stp;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset setting: ue = jx - ix, k0 = 1.0, uy = 1.0, alpha = 0
    task automatic test_hysteresis_branches();
        send_disp(0, 0, 0, 0, 1'b1);                 // no motion from reset
        send_disp(0, 0, HALF, 0, 1'b1);              // elastic loading
        send_disp(0, 0, 2 * ONE, 0, 1'b1);           // overshoot: upper bound
        send_disp(0, 0, 3 * ONE, 0, 1'b1);           // stay on hardening branch
        send_disp(0, 0, 5 * HALF, 0, 1'b1);          // reversal: unload on k0
        send_disp(0, 0, -3 * ONE, 0, 1'b0);          // probe only: lower bound
        send_disp(0, 0, 5 * HALF, 0, 1'b1);          // history kept: no motion
        send_disp(ONE, 0, -3 * ONE, 0, 1'b1);        // lower bound, committed
        send_disp(ONE, 0, -3 * ONE, 0, 1'b1);        // no motion while yielded
        send_disp(0, 0, -3 * ONE, 0, 1'b1);          // yielded, zero last step
        send_disp(DMAX, 0, DMIN, 0, 1'b1);           // deformation saturates low
        send_disp(DMIN, 0, DMAX, 0, 1'b1);           // and high, increment too
        // half hardening ratio: bounds now follow the deformation
        drain_responses();
        write_reg(REG_ALPHA, 32'd32768);
        send_disp(0, 0, 0, 0, 1'b1);
        send_disp(0, 0, 3 * ONE, 0, 1'b1);
        send_disp(0, 0, 4 * ONE, 0, 1'b1);
        send_disp(0, 0, -2 * ONE, 0, 1'b1);
        drain_responses();
    endtask

    task automatic test_register_extremes();
        // largest magnitudes everywhere: every product saturates somewhere
        load_settings({16'h8000, 16'h7fff, 16'h8000, 16'h7fff},
                      32'hffffffff, 31'h7fffffff, 16'hffff);
        send_disp(DMAX, DMIN, DMAX, DMIN, 1'b1);
        send_disp(DMIN, DMAX, DMIN, DMAX, 1'b1);
        send_disp(DMAX, DMAX, DMAX, DMAX, 1'b0);
        send_disp(0, 0, 0, 0, 1'b1);
        send_disp(DMIN, DMIN, DMIN, DMIN, 1'b1);
        drain_responses();
        // smallest settings: zero stiffness and zero yield
        load_settings({16'h8000, 16'h8000, 16'h8000, 16'h8000}, 32'h0, 31'h0, 16'h0);
        send_disp(DMIN, DMIN, DMIN, DMIN, 1'b1);
        send_disp(DMAX, DMAX, DMAX, DMAX, 1'b1);
        send_disp(0, 0, 0, 0, 1'b1);
        drain_responses();
        // zero yield with full hardening: yields on the first motion
        load_settings({16'h0000, 16'h4000, 16'h7fff, 16'h8000}, 32'h0001_0000, 31'h0, 16'hffff);
        send_disp(ONE, 0, 0, 0, 1'b1);
        send_disp(-ONE, 0, 0, 0, 1'b1);
        send_disp(2 * ONE, ONE, 0, -ONE, 1'b1);
        drain_responses();
    endtask

    task automatic test_random_settings();
        logic [3:0][15:0] cs;
        logic [31:0] k0;
        logic [30:0] uy;
        logic [15:0] alpha;
        for (int ph = 0; ph < 10; ph++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                case ($urandom_range(0, 7))
                    0:       cs[i] = 16'h8000;
                    1:       cs[i] = 16'h7fff;
                    2:       cs[i] = 16'h0000;
                    3:       cs[i] = 16'h4000;
                    4:       cs[i] = 16'hc000;
                    default: cs[i] = 16'($urandom);
                endcase
            end
            case ($urandom_range(0, 7))
                0:       k0 = 32'h0;
                1:       k0 = 32'hffffffff;
                2:       k0 = $urandom;
                default: k0 = $urandom_range(1 << 12, 1 << 20);
            endcase
            case ($urandom_range(0, 7))
                0:       uy = 31'h0;
                1:       uy = 31'h7fffffff;
                2:       uy = 31'($urandom);
                default: uy = 31'($urandom_range(1 << 10, 1 << 18));
            endcase
            case ($urandom_range(0, 3))
                0:       alpha = 16'h0;
                1:       alpha = 16'hffff;
                default: alpha = 16'($urandom);
            endcase
            // pin the first two phases to the extremes
            if (ph == 0)
            begin
                cs    = {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
                k0    = 32'hffffffff;
                uy    = 31'h7fffffff;
                alpha = 16'hffff;
            end
            else if (ph == 1)
            begin
                cs    = {16'h8000, 16'h8000, 16'h8000, 16'h8000};
                k0    = 32'h1;
                uy    = 31'h0;
                alpha = 16'h0;
            end
            load_settings(cs, k0, uy, alpha);
            // one phase runs back to back with no idling on either side
            idle_en = (ph != 2);
            run_walk(115);
            drain_responses();
        end
        idle_en = 1'b1;
    endtask

    // Hold the result channel off while steps keep coming, so the core
    // and result register fill and the input channel stalls
    task automatic test_output_holdoff();
        load_settings({16'h0000, 16'h0000, 16'h4000, 16'hc000},
                      32'h0002_0000, 31'h0001_0000, 16'h2000);
        idle_en     = 1'b0;
        holdoff_req = 1'b1;
        run_walk(60);
        drain_responses();
        idle_en = 1'b1;
    endtask

    // Pause the sender after each burst until every response is back
    task automatic test_drain_pause();
        load_settings({16'hc000, 16'h0000, 16'h4000, 16'h0000},
                      32'h0001_8000, 31'h0000_8000, 16'h1000);
        repeat (4)
        begin
            run_walk(25);
            drain_responses();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready with random gaps, plus the long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned hold_left;
        int unsigned gap_left;
        hold_left = 0;
        gap_left  = 0;
        resp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_req)
            begin
                holdoff_req = 1'b0;
                hold_left   = HOLDOFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                resp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                resp_ch.ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                resp_ch.ready <= 1'b1;
                if (idle_en && $urandom_range(0, 3) == 0)
                    gap_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response check: compare every transaction with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : response_check
        bhs_pkg::out_item_t got;
        bhs_pkg::out_item_t want;
        if (rst_n && resp_ch.valid && resp_ch.ready)
        begin
            got = {resp_ch.deformation, resp_ch.spring_force, resp_ch.tangent_stiffness,
                   resp_ch.yielded, resp_ch.node_force_0, resp_ch.node_force_1,
                   resp_ch.node_force_2, resp_ch.node_force_3};
            responses_seen++;
            if (response_forecast.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] response %0d arrived with nothing predicted",
                             $realtime, responses_seen);
            end
            else
            begin
                want = response_forecast.pop_front();
                if (want.yielded)
                    yielded_seen++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("[%0t] response %0d mismatch", $realtime, responses_seen);
                        $display("  want def=%h f=%h k=%h y=%b nf=%h %h %h %h",
                                 want.deformation, want.spring_force,
                                 want.tangent_stiffness, want.yielded, want.node_force_0,
                                 want.node_force_1, want.node_force_2, want.node_force_3);
                        $display("  got  def=%h f=%h k=%h y=%b nf=%h %h %h %h",
                                 got.deformation, got.spring_force,
                                 got.tangent_stiffness, got.yielded, got.node_force_0,
                                 got.node_force_1, got.node_force_2, got.node_force_3);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no transaction moves for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((step_ch.valid && step_ch.ready) || (resp_ch.valid && resp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
                 WATCHDOG_LIMIT, response_forecast.size());
        $display("bilinear_hysteretic_spring verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main
        // mirror the reset state of the block
        cfg_cos[0] = 16'hc000;
        cfg_cos[1] = 16'h0000;
        cfg_cos[2] = 16'h4000;
        cfg_cos[3] = 16'h0000;
        cfg_k0     = bhs_pkg::K0_RESET;
        cfg_uy     = 31'd65536;
        cfg_alpha  = 16'h0;
        hist_def   = '0;
        hist_inc   = '0;
        hist_force = '0;
        hist_stiff = bhs_pkg::K0_RESET;
        hist_yld   = 1'b0;
        idle_en     = 1'b1;
        holdoff_req = 1'b0;

        // drive every input to a known value and hold reset
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        step_ch.valid    <= 1'b0;
        step_ch.disp_i_x <= '0;
        step_ch.disp_i_z <= '0;
        step_ch.disp_j_x <= '0;
        step_ch.disp_j_z <= '0;
        step_ch.commit   <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_hysteresis_branches();
        test_register_extremes();
        test_random_settings();
        test_output_holdoff();
        test_drain_pause();

        drain_responses();
        repeat (END_SETTLE) @(posedge clk);

        $display("Run: %0d steps (%0d uncommitted), %0d responses, %0d on the hardening branch",
                 steps_sent, steps_uncommitted, responses_seen, yielded_seen);
        $display("Run: %0d register settings, %0d-cycle output hold-off, drain pauses, %0d bad",
                 settings_loaded, HOLDOFF_CYCLES, mismatches);
        if (mismatches == 0 && response_forecast.size() == 0)
            $display("bilinear_hysteretic_spring verification clean");
        else
            $display("bilinear_hysteretic_spring verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/bhs_pkg.sv
rtl/core/bhs_in_if.sv
rtl/core/bhs_out_if.sv
rtl/core/bhs_cfg.sv
rtl/core/bhs_mul.sv
rtl/core/bhs_core.sv
rtl/core/bilinear_hysteretic_spring.sv
test/bilinear_hysteretic_spring_tb.sv
